// ----- rtl/jse_pkg.sv -----
`default_nettype none
package jse_pkg;

	localparam int DATA_W      = 8;
	localparam int CNT_W       = 24;
	localparam int MODE_W      = 2;
	localparam int RUN_MAX     = 6;
	localparam int RUN_LEN_W   = 3;
	localparam int PEND_DEPTH  = 3;
	localparam int PEND_W      = 2;
	localparam int NEED_W      = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = 24'd4096;

	localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

	localparam logic [DATA_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [DATA_W-1:0] CH_BSL   = 8'h5C;
	localparam logic [DATA_W-1:0] CH_U     = 8'h75;
	localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic [RUN_MAX-1:0][DATA_W-1:0] bytes;
		logic [RUN_LEN_W-1:0]           len;
		logic                           failed;
		logic [CNT_W-1:0]               used;
	} run_t;

	function automatic logic [DATA_W-1:0] hex_digit(input logic [3:0] v);
		logic [DATA_W-1:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h57 + {4'd0, v};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/jse_if.sv -----
`default_nettype none
interface jse_in_if;
	logic                         valid;
	logic                         ready;
	logic [jse_pkg::MODE_W-1:0]   mode;
	logic [jse_pkg::DATA_W-1:0]   in_byte;
	modport source(output valid, output mode, output in_byte, input ready);
	modport sink(input valid, input mode, input in_byte, output ready);
endinterface

interface jse_out_if;
	logic                         valid;
	logic                         ready;
	logic [jse_pkg::DATA_W-1:0]   out_byte;
	logic                         byte_valid;
	logic                         last_of_run;
	logic                         writer_failed;
	logic [jse_pkg::CNT_W-1:0]    bytes_used;
	modport source(output valid, output out_byte, output byte_valid, output last_of_run,
		output writer_failed, output bytes_used, input ready);
	modport sink(input valid, input out_byte, input byte_valid, input last_of_run,
		input writer_failed, input bytes_used, output ready);
endinterface

interface jse_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [jse_pkg::CNT_W-1:0]    buffer_capacity;
	modport source(output valid, output buffer_capacity, input ready);
	modport sink(input valid, input buffer_capacity, output ready);
endinterface
`default_nettype wire

// ----- rtl/json_string_escaper.sv -----
// JSON string escaper with UTF-8 checking, writing into a bounded buffer.
// in_ch carries one command item: mode (open quote, data byte, close quote,
// clear) and in_byte. out_ch carries the output bytes of each item, one per
// item on the channel, with last_of_run on the final one; an item that
// appends nothing gives a single item with byte_valid low. writer_failed and
// bytes_used show the writer status after the command.
// cfg_ch writes buffer_capacity; write it only while the block is idle.
// Each command is written into the queue before its first output item is
// offered. Throughput: one command per cycle while each yields one item and
// the receiver keeps ready high; an escape of up to six bytes is sent by the
// serializer, which walks the run one byte per cycle while out_ch.ready is high.
// A two-entry queue lies between the command decoder and the serializer, so
// commands keep flowing while a run drains; in_ch.ready drops when that
// queue is full, which happens when the receiver stalls or when commands
// arrive faster than multi-byte runs drain.
// Reset: capacity 4096, nothing used, no failure, no pending sequence, queue
// empty. No clearing pass is needed.
`default_nettype none
module json_string_escaper (
	input  wire logic clk,
	input  wire logic arst_n,
	jse_in_if.sink    in_ch,
	jse_cfg_if.sink   cfg_ch,
	jse_out_if.source out_ch
);
	import jse_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	run_t push_data;
	run_t head;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_ch    (cfg_ch),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	jse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	jse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

// ----- rtl/jse_front.sv -----
`default_nettype none
module jse_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	jse_in_if.sink         in_ch,
	jse_cfg_if.sink        cfg_ch,
	input  wire logic      full,
	output logic           push,
	output jse_pkg::run_t  push_data
);
	import jse_pkg::*;

	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  used_q;
	logic              failed_q;
	logic [DATA_W-1:0] pb_q [PEND_DEPTH];
	logic [PEND_W-1:0] have_q;
	logic [NEED_W-1:0] need_q;

	logic [CNT_W-1:0]  used_d;
	logic              failed_d;
	logic [PEND_W-1:0] have_d;
	logic [NEED_W-1:0] need_d;
	logic              store_en;

	logic                           want;
	logic [RUN_LEN_W-1:0]           want_n;
	logic [RUN_MAX-1:0][DATA_W-1:0] want_bytes;
	logic                           fail_pre;
	logic [DATA_W-1:0]              b;
	logic [DATA_W-1:0]              lo;
	logic [DATA_W-1:0]              hi;
	logic [CNT_W:0]                 rem;
	logic                           fits;
	logic                           put_ok;

	assign b            = in_ch.in_byte;
	assign in_ch.ready  = !full;
	assign push         = in_ch.valid && !full;
	assign cfg_ch.ready = 1'b1;

	always_comb begin
		want       = 1'b0;
		want_n     = '0;
		want_bytes = '0;
		fail_pre   = failed_q;
		have_d     = have_q;
		need_d     = need_q;
		store_en   = 1'b0;
		lo         = 8'h80;
		hi         = 8'hBF;
		case (in_ch.mode)
			MODE_OPEN, MODE_CLOSE: begin
				if (need_q != '0) begin
					fail_pre = 1'b1;
					have_d   = '0;
					need_d   = '0;
				end
				want          = 1'b1;
				want_n        = 3'd1;
				want_bytes[0] = CH_QUOTE;
			end
			MODE_DATA: begin
				if (failed_q) begin
					have_d = '0;
					need_d = '0;
				end else if (need_q == '0) begin
					if (b < 8'h80) begin
						want          = 1'b1;
						want_bytes[0] = CH_BSL;
						if (b == CH_QUOTE || b == CH_BSL) begin
							want_n        = 3'd2;
							want_bytes[1] = b;
						end else if (b == 8'h08) begin
							want_n        = 3'd2;
							want_bytes[1] = 8'h62;
						end else if (b == 8'h0C) begin
							want_n        = 3'd2;
							want_bytes[1] = 8'h66;
						end else if (b == 8'h0A) begin
							want_n        = 3'd2;
							want_bytes[1] = 8'h6E;
						end else if (b == 8'h0D) begin
							want_n        = 3'd2;
							want_bytes[1] = 8'h72;
						end else if (b == 8'h09) begin
							want_n        = 3'd2;
							want_bytes[1] = 8'h74;
						end else if (b < 8'h20) begin
							want_n        = 3'd6;
							want_bytes[1] = CH_U;
							want_bytes[2] = CH_ZERO;
							want_bytes[3] = CH_ZERO;
							want_bytes[4] = hex_digit(b[7:4]);
							want_bytes[5] = hex_digit(b[3:0]);
						end else begin
							want_n        = 3'd1;
							want_bytes[0] = b;
						end
					end else if (b >= 8'hC2 && b <= 8'hDF) begin
						need_d   = 3'd2;
						have_d   = 2'd1;
						store_en = 1'b1;
					end else if (b >= 8'hE0 && b <= 8'hEF) begin
						need_d   = 3'd3;
						have_d   = 2'd1;
						store_en = 1'b1;
					end else if (b >= 8'hF0 && b <= 8'hF4) begin
						need_d   = 3'd4;
						have_d   = 2'd1;
						store_en = 1'b1;
					end else begin
						fail_pre = 1'b1;
					end
				end else begin
					if (have_q == 2'd1) begin
						if (pb_q[0] == 8'hE0) begin
							lo = 8'hA0;
						end else if (pb_q[0] == 8'hED) begin
							hi = 8'h9F;
						end else if (pb_q[0] == 8'hF0) begin
							lo = 8'h90;
						end else if (pb_q[0] == 8'hF4) begin
							hi = 8'h8F;
						end
					end
					if (b < lo || b > hi || have_q == '0) begin
						fail_pre = 1'b1;
						have_d   = '0;
						need_d   = '0;
					end else if ({1'b0, have_q} + 3'd1 < need_q) begin
						store_en = 1'b1;
						have_d   = have_q + 2'd1;
					end else begin
						want   = 1'b1;
						want_n = {1'b0, have_q} + 3'd1;
						for (int i = 0; i < PEND_DEPTH; i++) begin
							if (i < int'(have_q)) begin
								want_bytes[i] = pb_q[i];
							end
						end
						want_bytes[{1'b0, have_q}] = b;
						have_d = '0;
						need_d = '0;
					end
				end
			end
			default: begin
				have_d = '0;
				need_d = '0;
			end
		endcase
	end

	assign rem    = {1'b0, cap_q} - {1'b0, used_q};
	assign fits   = (cap_q != '0) && (used_q < cap_q) && ({22'd0, want_n} < rem);
	assign put_ok = want && !fail_pre && fits;

	always_comb begin
		if (in_ch.mode == MODE_CLEAR) begin
			used_d   = '0;
			failed_d = (cap_q == '0);
		end else begin
			used_d   = put_ok ? used_q + {21'd0, want_n} : used_q;
			failed_d = fail_pre || (want && !fits);
		end
	end

	always_comb begin
		push_data.bytes  = want_bytes;
		push_data.len    = put_ok ? want_n : '0;
		push_data.failed = failed_d;
		push_data.used   = used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			used_q   <= '0;
			failed_q <= (CAP_RESET == '0);
			have_q   <= '0;
			need_q   <= '0;
		end else begin
			if (cfg_ch.valid) begin
				cap_q <= cfg_ch.buffer_capacity;
			end
			if (push) begin
				used_q   <= used_d;
				failed_q <= failed_d;
				have_q   <= have_d;
				need_q   <= need_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && store_en) begin
			pb_q[have_q] <= b;
		end
	end

	a_have_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q != '0) |-> ({1'b0, have_q} < need_q && have_q != '0))
		else $error("pending count out of range");
	a_used_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.len != '0) |-> (used_d < cap_q))
		else $error("append past capacity");
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(push && failed_q && in_ch.mode != MODE_CLEAR) |-> (push_data.len == '0 && failed_d))
		else $error("failed writer appended");

endmodule
`default_nettype wire

// ----- rtl/jse_queue.sv -----
`default_nettype none
module jse_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  jse_pkg::run_t      push_data,
	output logic               full,
	input  wire logic          pop,
	output jse_pkg::run_t      pop_data,
	output logic               empty
);
	import jse_pkg::*;

	run_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue underflow");

endmodule
`default_nettype wire

// ----- rtl/jse_back.sv -----
`default_nettype none
module jse_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      empty,
	input  jse_pkg::run_t  head,
	output logic           pop,
	jse_out_if.source      out_ch
);
	import jse_pkg::*;

	logic [RUN_LEN_W-1:0] k_q;
	logic                 last;
	logic                 take;

	assign last = (head.len == '0) || (k_q == head.len - 3'd1);
	assign take = out_ch.valid && out_ch.ready;
	assign pop  = take && last;

	assign out_ch.valid         = !empty;
	assign out_ch.out_byte      = (head.len == '0) ? '0 : head.bytes[k_q];
	assign out_ch.byte_valid    = (head.len != '0);
	assign out_ch.last_of_run   = last;
	assign out_ch.writer_failed = head.failed;
	assign out_ch.bytes_used    = head.used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (take) begin
			k_q <= last ? '0 : k_q + 3'd1;
		end
	end

	a_index_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (k_q == '0 || k_q < head.len))
		else $error("byte index past run");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n) pop |=> (k_q == '0))
		else $error("index not restarted");

endmodule
`default_nettype wire
